// ===== sv/dttt_pkg.sv =====
// ----------------------------------------------------------------------------
// dttt_pkg: shared definitions for the deadline task timer table
// Table sizes, request codes, stream widths and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dttt_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 16;
	localparam int KEY_BITS    = 32;
	// Key bits that take part in the compare and are stored.
	localparam int KEY_W       = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Seconds to milliseconds.
	localparam logic [9:0] MS_PER_SEC = 10'd1000;

	// Request codes.
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_RUN    = 2'd2;

	// Result status codes.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Stream data widths, padded to whole bytes.
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 72;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the accepted request
		logic scan_start;  // restart the table scan and clear its results
		logic scan_en;     // issue the next table address
		logic commit;      // apply the table update and load the result
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;   // the address being issued is the last slot
		logic out_free;    // the result register can take a beat
		logic expired;     // the earliest task is due on a run request
	} dp_status_t;

endpackage

// ===== sv/dttt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dttt_ctrl: request sequencer of the deadline task timer table
// Accepts one request, steps the datapath through a table scan, waits for
// the result register and repeats the scan while due tasks remain.
// ----------------------------------------------------------------------------
module dttt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output dttt_pkg::ctrl_cmd_t    cmd,
	input  dttt_pkg::dp_status_t   st
);
	import dttt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_MERGE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		in_ready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load       = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (st.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_MERGE;
			end
			S_MERGE: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					if (st.expired) begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/dttt_datapath.sv =====
// ----------------------------------------------------------------------------
// dttt_datapath: task storage, scan and result register
// Holds the slot valid bits, the key and deadline memories, the request
// registers, the scan accumulators and the output beat register.
// ----------------------------------------------------------------------------
module dttt_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dttt_pkg::ctrl_cmd_t      cmd,
	output dttt_pkg::dp_status_t     st,
	input  logic [1:0]               req_type,
	input  logic [31:0]              task_key,
	input  logic signed [16:0]       delay_sec,
	input  logic [31:0]              now_ms,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_status,
	output logic                     out_expired,
	output logic [31:0]              out_key,
	output logic signed [31:0]       out_next,
	output logic [4:0]               out_count,
	output logic                     out_last
);
	import dttt_pkg::*;

	// Request registers.
	logic [1:0]        req_q;
	logic [KEY_W-1:0]  key_q;
	logic [16:0]       dly_q;
	logic [31:0]       now_q;

	// Deadline arithmetic.
	logic [25:0]       prod_s1;
	logic [31:0]       deadline_s2;
	logic [32:0]       sum;

	// Table storage.
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_next;
	logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
	logic [31:0]            dl_mem  [TABLE_DEPTH];

	// Scan pipeline.
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              cmp_en_s1;
	logic [KEY_W-1:0]  rd_key_s1;
	logic [31:0]       rd_dl_s1;

	// Scan accumulators.
	logic              hit_found_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              best_found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [31:0]       best_dl_q;
	logic [KEY_W-1:0]  best_key_q;
	logic              fin_found_q;
	logic [31:0]       fin_dl_q;

	// Compare stage and finish terms.
	logic              slot_v;
	logic              key_hit;
	logic              excl;
	logic              ins;
	logic              due;
	logic              expired;
	logic              full;
	logic [32:0]       diff;
	logic [31:0]       next_ms;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;

	// Capture the accepted request.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= task_key[KEY_W-1:0];
			dly_q <= delay_sec;
			now_q <= now_ms;
		end
	end

	// Deadline: now plus delay in milliseconds, saturated, or now if negative.
	assign sum = {1'b0, now_q} + 33'(prod_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= 26'(dly_q[15:0]) * 26'(MS_PER_SEC);
		if (dly_q[16]) begin
			deadline_s2 <= now_q;
		end else if (sum[32]) begin
			deadline_s2 <= 32'hFFFF_FFFF;
		end else begin
			deadline_s2 <= sum[31:0];
		end
	end

	// Scan address counter; it stops at the last slot.
	assign st.scan_last = (idx_q == IDX_W'(TABLE_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			cmp_en_s1 <= 1'b0;
		end else begin
			cmp_en_s1 <= cmd.scan_en;
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_en && !st.scan_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Key and deadline memories with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx] <= key_q;
			dl_mem[wr_idx]  <= deadline_s2;
		end
	end

	always_ff @(posedge clk) begin
		rd_key_s1  <= key_mem[idx_q];
		rd_dl_s1   <= dl_mem[idx_q];
		cmp_idx_s1 <= idx_q;
	end

	// Compare stage terms. The matched slot of an add or remove is left out
	// of the earliest search, since its deadline is replaced or dropped.
	assign slot_v  = valid_q[cmp_idx_s1];
	assign key_hit = slot_v && (rd_key_s1 == key_q);
	assign excl    = ((req_q == REQ_ADD) || (req_q == REQ_REMOVE)) && key_hit && !hit_found_q;

	// Scan accumulators: first key match, first free slot, earliest deadline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else if (cmp_en_s1) begin
			if (key_hit && !hit_found_q) begin
				hit_found_q <= 1'b1;
			end
			if (!slot_v && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (slot_v && !excl && (!best_found_q || (rd_dl_s1 < best_dl_q))) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en_s1) begin
			if (key_hit && !hit_found_q) begin
				hit_idx_q <= cmp_idx_s1;
			end
			if (!slot_v && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
			if (slot_v && !excl && (!best_found_q || (rd_dl_s1 < best_dl_q))) begin
				best_idx_q <= cmp_idx_s1;
				best_dl_q  <= rd_dl_s1;
				best_key_q <= rd_key_s1;
			end
		end
	end

	// Merge the new deadline of an add into the earliest deadline.
	assign ins = (req_q == REQ_ADD) && (hit_found_q || free_found_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_found_q <= 1'b0;
		end else begin
			fin_found_q <= best_found_q || ins;
		end
	end

	always_ff @(posedge clk) begin
		if (ins && (!best_found_q || (deadline_s2 < best_dl_q))) begin
			fin_dl_q <= deadline_s2;
		end else begin
			fin_dl_q <= best_dl_q;
		end
	end

	// Time to the next deadline, clamped at zero and saturated.
	assign diff    = {1'b0, fin_dl_q} - {1'b0, now_q};
	assign due     = fin_found_q && (fin_dl_q <= now_q);
	assign expired = (req_q == REQ_RUN) && due;
	assign full    = (req_q == REQ_ADD) && !hit_found_q && !free_found_q;

	always_comb begin
		if (!fin_found_q) begin
			next_ms = 32'hFFFF_FFFF;
		end else if (due) begin
			next_ms = '0;
		end else if (diff[31]) begin
			next_ms = 32'h7FFF_FFFF;
		end else begin
			next_ms = diff[31:0];
		end
	end

	assign st.expired  = expired;
	assign st.out_free = !out_valid || out_ready;

	// Table write on an add that refreshes or inserts.
	assign wr_en  = cmd.commit && ins;
	assign wr_idx = hit_found_q ? hit_idx_q : free_idx_q;

	// Task count after this beat's effect.
	always_comb begin
		count_next = count_q;
		if (cmd.commit) begin
			if (expired) begin
				count_next = count_q - CNT_W'(1);
			end else if ((req_q == REQ_ADD) && !hit_found_q && free_found_q) begin
				count_next = count_q + CNT_W'(1);
			end else if ((req_q == REQ_REMOVE) && hit_found_q) begin
				count_next = count_q - CNT_W'(1);
			end
		end
	end

	// Slot valid bits and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_next;
			if (cmd.commit) begin
				if (expired) begin
					valid_q[best_idx_q] <= 1'b0;
				end else if ((req_q == REQ_ADD) && !hit_found_q && free_found_q) begin
					valid_q[free_idx_q] <= 1'b1;
				end else if ((req_q == REQ_REMOVE) && hit_found_q) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
			end
		end
	end

	// Result beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status  <= expired ? STATUS_OK : (full ? STATUS_FULL : STATUS_OK);
			out_expired <= expired;
			out_key     <= expired ? 32'(best_key_q) : '0;
			out_next    <= expired ? '0 : next_ms;
			out_count   <= 5'(count_next);
			out_last    <= !expired;
		end
	end

endmodule

// ===== sv/deadline_task_timer_table.sv =====
// ----------------------------------------------------------------------------
// deadline_task_timer_table: table of pending timed tasks
// Adds, refreshes and removes keyed tasks with millisecond deadlines and
// reports due tasks earliest first, with the time to the next deadline.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents (low bits first)
// s_*      in   tuser: req_type; tdata: task_key, delay_sec, now_ms
// m_*      out  tuser: expired_valid; tlast: last;
//               tdata: status, expired_key, next_ms, pending_count
//
// Each request is one pass over the table, one slot a cycle through the single
// read port of the memories, then through the read, compare and merge registers
// to the result beat; the next request is taken once that beat is loaded. A run
// repeats the pass for each due task, one reported beat per pass. Reset clears the
// valid bits and the count at once. A stalled result beat holds the table;
// s_tready is high only between requests, also while a result waits on m_tready.
// ----------------------------------------------------------------------------
module deadline_task_timer_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] task_key, [48:32] delay_sec, [80:49] now_ms, [87:81] zero
	input  logic [dttt_pkg::IN_DATA_W-1:0] s_tdata,
	// [1:0] req_type
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] status, [32:1] expired_key, [64:33] next_ms, [69:65] pending_count,
	// [71:70] zero
	output logic [dttt_pkg::OUT_DATA_W-1:0] m_tdata,
	// [0] expired_valid
	output logic                           m_tuser,
	output logic                           m_tlast
);
	import dttt_pkg::*;

	ctrl_cmd_t          cmd;
	dp_status_t         st;
	logic               out_status;
	logic [31:0]        out_key;
	logic signed [31:0] out_next;
	logic [4:0]         out_count;

	// Request sequencer.
	dttt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	// Storage, scan and result register.
	dttt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.req_type    (s_tuser),
		.task_key    (s_tdata[31:0]),
		.delay_sec   (s_tdata[48:32]),
		.now_ms      (s_tdata[80:49]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (out_status),
		.out_expired (m_tuser),
		.out_key     (out_key),
		.out_next    (out_next),
		.out_count   (out_count),
		.out_last    (m_tlast)
	);

	// Pack the result beat.
	assign m_tdata = {2'b00, out_count, out_next, out_key, out_status};

endmodule

// ===== sv/dttt_checker.sv =====
// ----------------------------------------------------------------------------
// dttt_checker: port-level checks of the deadline task timer table
// Watches the stream ports for the kind of each result beat, field rules of expired
// task beats and the one-request-at-a-time acceptance.
// ----------------------------------------------------------------------------
module dttt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled result beat holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Every result beat is either an expired task report or the final beat of a request.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != m_tlast))
		else $error("result beat is neither a report nor a final beat");

	// An expired task report carries ok status and no next time.
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[0] == 1'b0) && (m_tdata[64:33] == 32'd0))
		else $error("expired task beat has status or next time set");

	// A request is taken only when the previous one has finished.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in progress");

endmodule

bind deadline_task_timer_table dttt_checker u_chk (.*);

// ===== verif/dttt_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// dttt_tb_pkg: shadow table and reply checker for the deadline task timer
// Keeps a copy of the task table, works out the reply beats of every accepted
// request and compares each reply beat from the block with the oldest one.
// ----------------------------------------------------------------------------
package dttt_tb_pkg;

	import dttt_pkg::*;

	// One reply beat, field by field.
	typedef struct {
		logic             status;
		logic             expired_valid;
		logic [31:0]      expired_key;
		logic [31:0]      next_ms;
		logic [CNT_W-1:0] pending_count;
		logic             last;
	} reply_t;

	class timer_table_shadow;

		bit               live[TABLE_DEPTH];
		logic [KEY_W-1:0] key_of[TABLE_DEPTH];
		logic [31:0]      due_of[TABLE_DEPTH];
		reply_t           pending_replies[$];
		int               error_count;
		int               reply_index;

		function new();
			foreach (live[i]) live[i] = 1'b0;
			error_count = 0;
			reply_index = 0;
		endfunction

		function bit busy();
			return pending_replies.size() != 0;
		endfunction

		function int count_live();
			int n;
			n = 0;
			foreach (live[i]) if (live[i]) n++;
			return n;
		endfunction

		// Lowest slot with the earliest deadline, or -1 for an empty table.
		function int earliest();
			int best;
			best = -1;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (live[i] && (best < 0 || due_of[i] < due_of[best])) best = i;
			end
			return best;
		endfunction

		// Time left to the earliest deadline, clamped to the positive range.
		function logic [31:0] time_to_next(logic [31:0] now);
			int s;
			logic [31:0] d;
			s = earliest();
			if (s < 0) return 32'hFFFF_FFFF;
			if (due_of[s] <= now) return 32'd0;
			d = due_of[s] - now;
			if (d > 32'h7FFF_FFFF) d = 32'h7FFF_FFFF;
			return d;
		endfunction

		function void push_reply(logic status, logic ev, logic [31:0] key,
				logic [31:0] next, logic last);
			reply_t r;
			r.status        = status;
			r.expired_valid = ev;
			r.expired_key   = key;
			r.next_ms       = next;
			r.pending_count = CNT_W'(count_live());
			r.last          = last;
			pending_replies.push_back(r);
		endfunction

		// Apply one accepted request and queue the replies it causes.
		function void note_request(logic [1:0] req, logic [31:0] key_in,
				logic [16:0] dly, logic [31:0] now);
			logic [KEY_W-1:0] key;
			logic [63:0]      sum;
			logic [31:0]      due;
			logic             status;
			int               hit;
			int               spare;
			int               s;
			key    = key_in[KEY_W-1:0];
			status = STATUS_OK;
			hit    = -1;
			spare  = -1;
			case (req)
				REQ_ADD: begin
					// A negative delay makes the task due at once.
					if (dly[16]) begin
						due = now;
					end else begin
						sum = 64'(now) + 64'(dly[15:0]) * 64'(MS_PER_SEC);
						due = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
					end
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (live[i]) begin
							if (hit < 0 && key_of[i] == key) hit = i;
						end else if (spare < 0) begin
							spare = i;
						end
					end
					if (hit >= 0) begin
						due_of[hit] = due;
					end else if (spare >= 0) begin
						live[spare]   = 1'b1;
						key_of[spare] = key;
						due_of[spare] = due;
					end else begin
						status = STATUS_FULL;
					end
				end
				REQ_REMOVE: begin
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (live[i] && key_of[i] == key) begin
							live[i] = 1'b0;
							break;
						end
					end
				end
				REQ_RUN: begin
					// Report due tasks earliest first, removing each one.
					forever begin
						s = earliest();
						if (s < 0 || due_of[s] > now) break;
						live[s] = 1'b0;
						push_reply(STATUS_OK, 1'b1, 32'(key_of[s]), 32'd0, 1'b0);
					end
				end
				default: ;
			endcase
			push_reply(status, 1'b0, 32'd0, time_to_next(now), 1'b1);
		endfunction

		task report_mismatch(string msg);
			if (error_count < 50) $display("[%0t] mismatch: %s", $time, msg);
			error_count++;
		endtask

		// Compare one reply beat from the block with the oldest expected one.
		task check_result(logic status, logic ev, logic [31:0] key,
				logic [31:0] next, logic [CNT_W-1:0] count, logic last);
			reply_t e;
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("reply beat %0d with nothing expected",
					reply_index));
			end else begin
				e = pending_replies.pop_front();
				if (status !== e.status)
					report_mismatch($sformatf("beat %0d status %b, expected %b",
						reply_index, status, e.status));
				if (ev !== e.expired_valid)
					report_mismatch($sformatf("beat %0d expired_valid %b, expected %b",
						reply_index, ev, e.expired_valid));
				if (key !== e.expired_key)
					report_mismatch($sformatf("beat %0d expired_key %h, expected %h",
						reply_index, key, e.expired_key));
				if (next !== e.next_ms)
					report_mismatch($sformatf("beat %0d next_ms %h, expected %h",
						reply_index, next, e.next_ms));
				if (count !== e.pending_count)
					report_mismatch($sformatf("beat %0d pending_count %0d, expected %0d",
						reply_index, count, e.pending_count));
				if (last !== e.last)
					report_mismatch($sformatf("beat %0d last %b, expected %b",
						reply_index, last, e.last));
			end
			reply_index++;
		endtask

	endclass

endpackage

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the deadline task timer table
// Drives add, remove and run requests with a moving clock value, first a
// directed set (empty table, saturation, full table, a run that empties a
// full table), then random traffic under three idling patterns, and checks
// every reply beat against a shadow copy of the table.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import dttt_pkg::*;
	import dttt_tb_pkg::*;

	// The fourth request code is unused and must leave the table alone.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [16:0] DELAY_NOW = 17'h1FFFF;
	localparam int POOL_SIZE = 24;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	int tx_idle_pct = 8;
	int rx_idle_pct = 60;

	timer_table_shadow table_shadow = new();

	deadline_task_timer_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The receiver stalls at random on the falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Check each reply beat taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			table_shadow.check_result(m_tdata[0], m_tuser, m_tdata[32:1],
				m_tdata[64:33], m_tdata[69:65], m_tlast);
		end
	end

	// Offer one request beat after a random gap and wait for its accept.
	task send_request(logic [1:0] req, logic [31:0] key, logic [16:0] dly,
			logic [31:0] now);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {7'd0, now, dly, key};
		do @(posedge clk); while (!s_tready);
		table_shadow.note_request(req, key, dly, now);
	endtask

	// Hold off the sender until every queued reply has come back.
	task wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (table_shadow.busy()) @(posedge clk);
	endtask

	initial begin
		logic [31:0] key_pool[POOL_SIZE];
		logic [31:0] cur_now;
		logic [31:0] key;
		logic [31:0] now;
		logic [16:0] dly;
		logic [1:0]  req;
		int          sel;
		int          pick;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, unused code and absent remove.
		send_request(REQ_RUN, 32'd0, 17'd0, 32'd0);
		send_request(REQ_REMOVE, 32'h0000_1234, 17'd0, 32'd5);
		send_request(REQ_UNUSED, 32'hFFFF_FFFF, DELAY_NOW, 32'hFFFF_FFFF);
		// Deadline sum saturates at the top of the range.
		send_request(REQ_ADD, 32'hFFFF_FFFF, 17'd65535, 32'hFFF0_0000);
		// Time far before that deadline clamps next_ms to the largest positive.
		send_request(REQ_REMOVE, 32'd0, 17'd0, 32'd0);
		// A negative delay is due now, then the same key is refreshed.
		send_request(REQ_ADD, 32'd0, DELAY_NOW, 32'h0000_1000);
		send_request(REQ_ADD, 32'd0, 17'd3, 32'h0000_1000);
		// Fill the table.
		for (int i = 2; i < TABLE_DEPTH; i++) begin
			send_request(REQ_ADD, 32'hA5C3_0000 | 32'(i), 17'(i % 4), 32'h0000_2000);
		end
		// A new key on a full table is refused; an existing key still refreshes.
		send_request(REQ_ADD, 32'h5A3C_FFFF, 17'd1, 32'h0000_2000);
		send_request(REQ_ADD, 32'hFFFF_FFFF, 17'd0, 32'h0000_2000);
		// Everything is due: sixteen expired beats, ties in slot order.
		send_request(REQ_RUN, 32'd0, 17'd0, 32'h0000_3000);
		wait_drained();

		// Random traffic: a key pool and a clock that mostly moves forward.
		foreach (key_pool[i]) key_pool[i] = $urandom;
		cur_now = $urandom;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 8;
					rx_idle_pct = 60;
				end
				1: begin
					tx_idle_pct = 60;
					rx_idle_pct = 8;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < 100; n++) begin
				cur_now += $urandom_range(1500);
				sel = $urandom_range(99);
				pick = $urandom_range(POOL_SIZE - 1);
				key = ($urandom_range(9) == 0) ? $urandom : key_pool[pick];
				dly = 17'd0;
				now = cur_now;
				if (sel < 45) begin
					req = REQ_ADD;
					case ($urandom_range(19))
						0: dly = DELAY_NOW;
						1: dly = 17'($urandom_range(65535));
						default: dly = 17'($urandom_range(8));
					endcase
				end else if (sel < 65) begin
					req = REQ_REMOVE;
				end else if (sel < 95) begin
					req = REQ_RUN;
					cur_now += $urandom_range(6000);
					now = cur_now;
				end else begin
					// Noise: any code, any time, any delay in range.
					req = 2'($urandom_range(3));
					key = $urandom;
					now = $urandom;
					dly = ($urandom_range(1) == 0) ? DELAY_NOW : 17'($urandom_range(65535));
				end
				send_request(req, key, dly, now);
				if ($urandom_range(49) == 0) wait_drained();
			end
			wait_drained();
		end

		// Drain and give the block time to show any stray beat.
		repeat (60) @(posedge clk);
		if (table_shadow.error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Timeout well beyond the slowest correct run.
	initial begin
		#8_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
